// ===== sv/ivalloc_pkg.sv =====
// Shared types, constants and helpers for the interrupt vector allocator.
package ivalloc_pkg;

  localparam int SLOT_COUNT = 16;
  localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int VEC_W      = 8;
  localparam int TAG_W      = 16;
  localparam int CNT_W      = 32;

  // Request opcodes
  typedef enum logic [1:0] {
    CMD_CLAIM    = 2'd0,
    CMD_RELEASE  = 2'd1,
    CMD_DISPATCH = 2'd2,
    CMD_STATS    = 2'd3
  } cmd_t;

  // Counter update from the request stage to the statistics bank
  typedef struct packed {
    logic              take;     // dispatch hit an in-range slot
    logic              unowned;  // that slot was free
    logic [SLOT_W-1:0] slot;
    logic              exhaust;  // claim found no free slot
  } stat_upd_t;

  // Saturating increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = (&c) ? c : c + CNT_W'(1);
    return r;
  endfunction

endpackage

// ===== sv/irq_vector_allocator_core.sv =====
// Interrupt vector allocator: request register, slot logic, result register.
// A request waits in the request register until the result register is free
// or draining. Throughput: one request per cycle unless the output stalls;
// the free-slot encode and counter read-modify-write close in the request stage.
// Reset (rst, synchronous): all slots free, counters zero, vector_base 64.
// Tags are not reset; a tag is read only while its slot is owned.
module irq_vector_allocator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ivalloc_pkg::VEC_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    cmd,
  input  logic [ivalloc_pkg::VEC_W-1:0] vector_num,
  input  logic                          handler_present,
  input  logic [15:0]                   handler_tag,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          ok,
  output logic [ivalloc_pkg::VEC_W-1:0] granted_vector,
  output logic [15:0]                   owner_tag,
  output logic [ivalloc_pkg::CNT_W-1:0] taken_count,
  output logic [ivalloc_pkg::CNT_W-1:0] unowned_count,
  output logic [ivalloc_pkg::CNT_W-1:0] exhausted_count
);
  import ivalloc_pkg::*;

  localparam logic [VEC_W-1:0] BASE_RESET = VEC_W'(64);

  logic [VEC_W-1:0]      vector_base;
  logic [SLOT_COUNT-1:0] slot_owned;
  logic [TAG_W-1:0]      slot_tag [SLOT_COUNT];

  // Request register
  logic             req_valid;
  cmd_t             req_cmd;
  logic [VEC_W-1:0] req_vnum;
  logic             req_present;
  logic [TAG_W-1:0] req_tag;

  logic advance;
  logic [VEC_W:0]    diff;
  logic              in_range;
  logic [SLOT_W-1:0] hit_slot;
  logic              free_found;
  logic [SLOT_W-1:0] free_slot;
  logic [VEC_W-1:0]  free_vector;
  logic              grant;
  stat_upd_t         upd;
  logic [CNT_W-1:0]  rd_taken, rd_unowned, exhaust;

  logic             ok_next;
  logic [VEC_W-1:0] granted_next;
  logic [15:0]      owner_next;
  logic [CNT_W-1:0] taken_next, unowned_next, exh_next;

  // Handshake: request stage moves when the result register is free or draining
  assign advance   = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      vector_base <= BASE_RESET;
    end else if (cfg_valid) begin
      vector_base <= cfg_data;
    end
  end

  // Capture request
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ready) begin
      req_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_cmd     <= cmd_t'(cmd);
      req_vnum    <= vector_num;
      req_present <= handler_present;
      req_tag     <= TAG_W'(handler_tag);
    end
  end

  // Vector to slot decode
  assign diff     = {1'b0, req_vnum} - {1'b0, vector_base};
  assign in_range = !diff[VEC_W] && (diff < (VEC_W + 1)'(SLOT_COUNT));
  assign hit_slot = diff[SLOT_W-1:0];

  ivalloc_free_finder u_finder (
    .base   (vector_base),
    .owned  (slot_owned),
    .found  (free_found),
    .slot   (free_slot),
    .vector (free_vector)
  );

  ivalloc_stat_bank u_stats (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .rd_slot    (hit_slot),
    .rd_taken   (rd_taken),
    .rd_unowned (rd_unowned),
    .exhaust    (exhaust)
  );

  assign grant = advance && (req_cmd == CMD_CLAIM) && req_present && free_found;

  // Counter updates for this request
  always_comb begin
    upd.take    = advance && (req_cmd == CMD_DISPATCH) && in_range;
    upd.unowned = !slot_owned[hit_slot];
    upd.slot    = hit_slot;
    upd.exhaust = advance && (req_cmd == CMD_CLAIM) && req_present && !free_found;
  end

  // Result for this request
  always_comb begin
    ok_next      = 1'b0;
    granted_next = '0;
    owner_next   = '0;
    taken_next   = '0;
    unowned_next = '0;
    exh_next     = '0;
    unique case (req_cmd)
      CMD_CLAIM: begin
        if (req_present && free_found) begin
          ok_next      = 1'b1;
          granted_next = free_vector;
        end
      end
      CMD_RELEASE: begin
        ok_next = in_range;
      end
      CMD_DISPATCH: begin
        if (in_range && slot_owned[hit_slot]) begin
          ok_next    = 1'b1;
          owner_next = 16'(slot_tag[hit_slot]);
        end
      end
      CMD_STATS: begin
        if (in_range) begin
          ok_next      = 1'b1;
          taken_next   = rd_taken;
          unowned_next = rd_unowned;
        end
        exh_next = exhaust;
      end
      default: ;
    endcase
  end

  // Slot ownership
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_owned <= '0;
    end else if (grant) begin
      slot_owned[free_slot] <= 1'b1;
    end else if (advance && (req_cmd == CMD_RELEASE) && in_range) begin
      slot_owned[hit_slot] <= 1'b0;
    end
  end

  // Owner tags
  always_ff @(posedge clk) begin
    if (grant) begin
      slot_tag[free_slot] <= req_tag;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ok              <= ok_next;
      granted_vector  <= granted_next;
      owner_tag       <= owner_next;
      taken_count     <= taken_next;
      unowned_count   <= unowned_next;
      exhausted_count <= exh_next;
    end
  end

`ifndef SYNTHESIS
  // A grant never hands out a slot that is already owned
  assert property (@(posedge clk) disable iff (rst)
    grant |-> !slot_owned[free_slot])
    else $error("claim granted an owned slot");

  // A nonzero granted vector only comes with ok
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && (granted_vector != '0)) |-> ok)
    else $error("granted vector without ok");

  // Exhaustion counter never decreases
  assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (exhaust >= $past(exhaust)))
    else $error("exhaustion counter went backwards");

  // A claimed slot is owned afterward
  assert property (@(posedge clk) disable iff (rst)
    grant |=> slot_owned[$past(free_slot)])
    else $error("granted slot not marked owned");
`endif

endmodule

// ===== sv/ivalloc_free_finder.sv =====
// Lowest free slot search with vector encodability check.
module ivalloc_free_finder (
  input  logic [ivalloc_pkg::VEC_W-1:0]      base,
  input  logic [ivalloc_pkg::SLOT_COUNT-1:0] owned,
  output logic                               found,
  output logic [ivalloc_pkg::SLOT_W-1:0]     slot,
  output logic [ivalloc_pkg::VEC_W-1:0]      vector
);
  import ivalloc_pkg::*;

  logic [VEC_W:0]          slot_vec [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   eligible;

  // A slot is usable if free and its vector is nonzero and fits in 8 bits
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_vec[i] = {1'b0, base} + (VEC_W + 1)'(i);
      eligible[i] = !owned[i] && (slot_vec[i] != '0) && !slot_vec[i][VEC_W];
    end
  end

  // Priority encode, lowest index wins
  always_comb begin
    found = 1'b0;
    slot  = '0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (eligible[i]) begin
        found = 1'b1;
        slot  = SLOT_W'(i);
      end
    end
    vector = base + VEC_W'(slot);
  end

endmodule

// ===== sv/ivalloc_stat_bank.sv =====
// Per-slot dispatch counters and the claim exhaustion counter.
module ivalloc_stat_bank (
  input  logic                          clk,
  input  logic                          rst,
  input  ivalloc_pkg::stat_upd_t        upd,
  input  logic [ivalloc_pkg::SLOT_W-1:0] rd_slot,
  output logic [ivalloc_pkg::CNT_W-1:0] rd_taken,
  output logic [ivalloc_pkg::CNT_W-1:0] rd_unowned,
  output logic [ivalloc_pkg::CNT_W-1:0] exhaust
);
  import ivalloc_pkg::*;

  logic [CNT_W-1:0] taken   [SLOT_COUNT];
  logic [CNT_W-1:0] unowned [SLOT_COUNT];

  // Read port at the request's slot
  assign rd_taken   = taken[rd_slot];
  assign rd_unowned = unowned[rd_slot];

  // Saturating counter updates
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        taken[i]   <= '0;
        unowned[i] <= '0;
      end
      exhaust <= '0;
    end else begin
      if (upd.take) begin
        taken[upd.slot] <= sat_inc(taken[upd.slot]);
      end
      if (upd.take && upd.unowned) begin
        unowned[upd.slot] <= sat_inc(unowned[upd.slot]);
      end
      if (upd.exhaust) begin
        exhaust <= sat_inc(exhaust);
      end
    end
  end

endmodule
